[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the address translation block.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge of clock while reset is low.
`define SRAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that an expression is never true while reset is low.
`define SRAT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`else

`define SRAT_ASSERT(lbl, prop, msg)
`define SRAT_NEVER(lbl, expr, msg)

`endif

`endif

[rtl/core/srat_pkg.sv]
// Types and constants of the section range address translation block.
// Used by the chain cell and the top level; depends on nothing.
package srat_pkg;

   // Request commands.
   typedef enum logic {
      CMD_LOAD      = 1'b0,
      CMD_TRANSLATE = 1'b1
   } srat_cmd_type;

   // Configuration register indexes.
   typedef logic [7:0] srat_csr_index_type;
   localparam srat_csr_index_type CSR_FILE_ALIGNMENT = 8'd0;
   localparam srat_csr_index_type CSR_SECTION_COUNT  = 8'd1;

   localparam int ALIGN_WIDTH = 17;
   localparam int COUNT_WIDTH = 5;
   localparam logic [ALIGN_WIDTH-1:0] ALIGN_RESET = 17'd512;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 5'd0;

   // One request on the input channel.
   typedef struct packed {
      srat_cmd_type command;
      logic [3:0]   slot;
      logic [31:0]  section_start;
      logic [31:0]  section_length;
      logic [31:0]  raw_pointer;
      logic [31:0]  rva;
   } srat_req_type;

   // One result on the output channel.
   typedef struct packed {
      logic [31:0] file_offset;
      logic        hit;
   } srat_rsp_type;

   // A request as it travels along the chain of cells.
   typedef struct packed {
      logic         valid;
      srat_req_type req;
      logic         hit;
      logic [31:0]  file_offset;
   } srat_token_type;

   // Control shared by every cell of the chain.
   typedef struct packed {
      logic                   advance;
      logic [31:0]            raw_mask;
      logic [COUNT_WIDTH-1:0] section_count;
   } srat_ctrl_type;

endpackage

[rtl/core/srat_cell.sv]
// One cell of the translation chain: holds a single section entry and checks
// the request passing through it. Depends on srat_pkg.
module srat_cell
   import srat_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  srat_ctrl_type  ctrl,
   input  srat_token_type tok_i,
   output srat_token_type tok_o
);

   logic [31:0]    start_ff, start_in;
   logic [31:0]    end_ff, end_in;
   logic [31:0]    raw_ff, raw_in;
   srat_token_type tok_ff, tok_in;
   logic           load_here;
   logic           active;
   logic           in_range;

   // A load request writes this entry as it passes, if its slot is ours.
   always_comb begin
      load_here = ctrl.advance && tok_i.valid && (tok_i.req.command == CMD_LOAD)
                  && (32'(tok_i.req.slot) == 32'(CELL_INDEX));
      start_in  = tok_i.req.section_start;
      end_in    = tok_i.req.section_start + tok_i.req.section_length;
      raw_in    = tok_i.req.raw_pointer;
   end

   always_ff @(posedge clock) begin
      if (load_here) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         raw_ff   <= raw_in;
      end
   end

   // Only the first matching entry among the searched ones claims a translation.
   always_comb begin
      active   = 32'(CELL_INDEX) < 32'(ctrl.section_count);
      in_range = (tok_i.req.rva >= start_ff) && (tok_i.req.rva < end_ff);
      tok_in   = tok_i;
      if (tok_i.valid && (tok_i.req.command == CMD_TRANSLATE) && !tok_i.hit
          && active && in_range) begin
         tok_in.hit         = 1'b1;
         tok_in.file_offset = tok_i.req.rva - start_ff + (raw_ff & ctrl.raw_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (ctrl.advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

[rtl/core/section_range_address_translate.sv]
// Top level of the section range address translation block: configuration
// registers, the chain of entry cells and the result register. Depends on
// srat_pkg, srat_cell and assert_macros.svh.
//
//   Channel  Ports                       Carries
//   req      req_valid/ready/payload     load or translate request
//   rsp      rsp_valid/ready/payload     file offset and hit flag
//   csr      csr_valid/ready/index/wdata register write, always ready
//
// Every request walks the chain, one cell a cycle while it advances, through the
// cell registers and the result register; a request may enter each unstalled cycle.
// Loads travel the chain as well, so each entry changes in request order.
// When a finished result meets a full result register that is not being taken,
// the whole chain stalls and req_ready falls until the register drains.
// Synchronous reset empties the chain and restores both registers.
`include "assert_macros.svh"

module section_range_address_translate
   import srat_pkg::*;
#(
   parameter int MAX_SECTIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  srat_req_type       req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output srat_rsp_type       rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  srat_csr_index_type csr_index,
   input  logic [ALIGN_WIDTH-1:0] csr_wdata
);

   logic [ALIGN_WIDTH-1:0] file_alignment_ff, file_alignment_in;
   logic [COUNT_WIDTH-1:0] section_count_ff, section_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   srat_rsp_type           rsp_payload_ff, rsp_payload_in;
   srat_ctrl_type          ctrl;
   srat_token_type         chain [0:MAX_SECTIONS];
   srat_token_type         tail;
   logic                   tail_take;
   logic                   advance;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_comb begin
      file_alignment_in = file_alignment_ff;
      section_count_in  = section_count_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILE_ALIGNMENT: file_alignment_in = csr_wdata;
            CSR_SECTION_COUNT:  section_count_in  = csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_alignment_ff <= ALIGN_RESET;
         section_count_ff  <= COUNT_RESET;
      end else begin
         file_alignment_ff <= file_alignment_in;
         section_count_ff  <= section_count_in;
      end
   end

   // The chain moves unless a finished translation cannot leave.
   assign tail      = chain[MAX_SECTIONS];
   assign tail_take = tail.valid && (tail.req.command == CMD_TRANSLATE);
   assign advance   = !tail_take || !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      ctrl.advance       = advance;
      ctrl.raw_mask      = ~(32'(file_alignment_ff) - 32'd1);
      ctrl.section_count = section_count_ff;
   end

   // The request enters the first cell with no match yet.
   always_comb begin
      chain[0].valid       = req_valid;
      chain[0].req         = req_payload;
      chain[0].hit         = 1'b0;
      chain[0].file_offset = 32'd0;
   end

   for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
      srat_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .tok_i (chain[i]),
         .tok_o (chain[i+1])
      );
   end

   // Result register between the chain and the output channel.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (tail_take && advance) begin
         rsp_valid_in               = 1'b1;
         rsp_payload_in.hit         = tail.hit;
         rsp_payload_in.file_offset = tail.file_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Checks on the chain and the result register.
   `SRAT_ASSERT(a_stall_cause, !req_ready |-> (rsp_valid_ff && tail_take), "chain stalled without cause")
   `SRAT_NEVER(a_load_no_hit, tail.valid && (tail.req.command == CMD_LOAD) && tail.hit, "load request marked as hit")
   `SRAT_ASSERT(a_miss_zero, (rsp_valid_ff && !rsp_payload_ff.hit) |-> (rsp_payload_ff.file_offset == 32'd0), "miss with non-zero offset")

endmodule
